// ===== rtl/core/lns_pkg.sv =====
`default_nettype none

package lns_pkg;

    localparam int unsigned LANES  = 8;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam int unsigned LANE_W = $clog2(LANES);

    typedef logic [1:0] sample_t;

    typedef enum logic [1:0] {
        MODE_BIT_DIFF      = 2'd0,
        MODE_ZERO_DIFF     = 2'd1,
        MODE_THREE_REJECT  = 2'd2,
        MODE_NIBBLE_REJECT = 2'd3
    } mode_t;

    // byte or mode 2 group, classified: which lanes hold a sample, their values
    typedef struct packed {
        logic [LANES-1:0]    keep;
        sample_t [LANES-1:0] vals;
    } job_t;

    // control between the queue and its two sides
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lns_front.sv =====
`default_nettype none

module lns_front
    import lns_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_stream,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire q_sts_t     q_sts,
    output logic            push,
    output job_t            push_job
);

    mode_t       mode_reg;
    logic [15:0] gathered_reg;
    logic [15:0] gathered_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [23:0] word;
    logic        accept;
    job_t        job;

    assign accept   = in_valid && !q_sts.full;
    assign in_stall = q_sts.full;
    assign word     = {data_byte, gathered_reg};

    always_comb
    begin
        logic [3:0] nib;
        logic [2:0] cand;
        job           = '0;
        gathered_next = gathered_reg;
        phase_next    = phase_reg;
        nib           = '0;
        cand          = '0;
        case (mode_reg)
            MODE_BIT_DIFF:
            begin
                gathered_next = '0;
                phase_next    = '0;
                for (int k = 0; k < 4; k++)
                begin
                    job.keep[k] = 1'b1;
                    job.vals[k] = sample_t'({1'b0, data_byte[2*k+1]})
                                - sample_t'({1'b0, data_byte[2*k]});
                end
            end
            MODE_ZERO_DIFF:
            begin
                gathered_next = '0;
                phase_next    = '0;
                for (int k = 0; k < 2; k++)
                begin
                    nib         = data_byte[4*k +: 4];
                    job.keep[k] = 1'b1;
                    job.vals[k] = sample_t'({1'b0, nib[1:0] == 2'd0})
                                - sample_t'({1'b0, nib[3:2] == 2'd0});
                end
            end
            MODE_THREE_REJECT:
            begin
                if (phase_reg == 2'd1)
                begin
                    gathered_next = {data_byte, gathered_reg[7:0]};
                    phase_next    = 2'd2;
                end
                else if (phase_reg == 2'd2)
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        cand        = word[3*k +: 3];
                        job.keep[k] = cand < 3'd6;
                        job.vals[k] = {1'b0, cand == 3'd0};
                    end
                    gathered_next = '0;
                    phase_next    = '0;
                end
                else
                begin
                    gathered_next = {8'h00, data_byte};
                    phase_next    = 2'd1;
                end
            end
            MODE_NIBBLE_REJECT:
            begin
                gathered_next = '0;
                phase_next    = '0;
                for (int k = 0; k < 2; k++)
                begin
                    nib         = data_byte[4*k +: 4];
                    job.keep[k] = nib < 4'd12;
                    job.vals[k] = {1'b0, nib == 4'd0};
                end
            end
            default:
            begin
                gathered_next = '0;
                phase_next    = '0;
            end
        endcase
        if (end_of_stream)
        begin
            gathered_next = '0;
            phase_next    = '0;
        end
    end

    assign push     = accept && (|job.keep);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_BIT_DIFF;
            gathered_reg <= '0;
            phase_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= mode_t'(cfg_wr_data);
            end
            if (accept)
            begin
                gathered_reg <= gathered_next;
                phase_reg    <= phase_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lns_fifo.sv =====
`default_nettype none

module lns_fifo
    import lns_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire q_ctl_t q_ctl,
    input  wire job_t   wr_job,
    output q_sts_t      q_sts,
    output job_t        rd_job
);

    job_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_sts.full  = count_reg == QCNT_W'(QDEPTH);
    assign q_sts.valid = count_reg != '0;
    assign do_push     = q_ctl.push && !q_sts.full;
    assign do_pop      = q_ctl.pop && q_sts.valid;
    assign rd_job      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lns_back.sv =====
`default_nettype none

module lns_back
    import lns_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire q_sts_t q_sts,
    input  wire job_t   rd_job,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic signed [1:0] sample_value,
    output logic        last_of_run
);

    logic [LANES-1:0]    keep_reg;
    logic [LANES-1:0]    keep_next;
    sample_t [LANES-1:0] vals_reg;
    logic                valid_reg;
    sample_t             sample_reg;
    logic                last_reg;
    logic                load;
    logic                emit;
    logic [LANES-1:0]    low_bit;
    logic [LANES-1:0]    remain;
    logic [LANE_W-1:0]   sel;

    // lowest kept lane goes out first
    assign low_bit = keep_reg & (~keep_reg + LANES'(1));

    always_comb
    begin
        sel = '0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (keep_reg[k])
            begin
                sel = LANE_W'(k);
            end
        end
    end

    assign load   = !valid_reg || !out_stall;
    assign emit   = load && (|keep_reg);
    assign remain = emit ? (keep_reg & ~low_bit) : keep_reg;
    assign pop    = q_sts.valid && (remain == '0);

    always_comb
    begin
        keep_next = remain;
        if (pop)
        begin
            keep_next = rd_job.keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            vals_reg <= rd_job.vals;
        end
        if (emit)
        begin
            sample_reg <= vals_reg[sel];
            last_reg   <= remain == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            keep_reg <= keep_next;
            if (load)
            begin
                valid_reg <= emit;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign sample_value = sample_reg;
    assign last_of_run  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lattice_noise_sampler.sv =====
// a request's samples pass through the queue entry, the serializer's lane register
// and the output sample register; the output stage gives one sample per cycle while
// out_stall is low (4 samples per byte in mode 0, up to 8 for a completed mode 2 group)
// a four-entry queue between classification and the sample serializer absorbs bursts
// reset: asynchronous, active low; mode 0, empty group, empty queue, no output
`default_nettype none

module lattice_noise_sampler
    import lns_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_stream,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic signed [1:0] sample_value,
    output logic            last_of_run
);

    q_ctl_t q_ctl;
    q_sts_t q_sts;
    job_t   wr_job;
    job_t   rd_job;
    logic   push;
    logic   pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    lns_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_sts         (q_sts),
        .push          (push),
        .push_job      (wr_job)
    );

    lns_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ctl  (q_ctl),
        .wr_job (wr_job),
        .q_sts  (q_sts),
        .rd_job (rd_job)
    );

    lns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_sts        (q_sts),
        .rd_job       (rd_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

// ===== sim/lns_checker.sv =====
`default_nettype none

module lns_checker
    import lns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_stream,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic signed [1:0] sample_value,
    input  wire logic              last_of_run,
    output int unsigned            pending,
    output int unsigned            errors
);

    typedef struct packed {
        sample_t value;
        logic    last;
    } noise_sample_t;

    noise_sample_t sample_q [$];
    mode_t         mode;
    logic [15:0]   grp_bytes;
    logic [1:0]    grp_phase;

    task automatic predict_samples(input logic [7:0] b, input logic eos);
        sample_t     vals [8];
        int          n;
        logic [23:0] word;
        logic [2:0]  cand;
        logic [3:0]  nib;
        noise_sample_t s;
        n = 0;
        case (mode)
            MODE_BIT_DIFF:
            begin
                grp_bytes = '0;
                grp_phase = '0;
                for (int k = 0; k < 4; k++)
                begin
                    vals[n] = {1'b0, b[2*k+1]} - {1'b0, b[2*k]};
                    n++;
                end
            end
            MODE_ZERO_DIFF:
            begin
                grp_bytes = '0;
                grp_phase = '0;
                for (int k = 0; k < 2; k++)
                begin
                    nib = b[4*k +: 4];
                    vals[n] = {1'b0, nib[1:0] == 2'b00} - {1'b0, nib[3:2] == 2'b00};
                    n++;
                end
            end
            MODE_THREE_REJECT:
            begin
                if (grp_phase == 2'd1)
                begin
                    grp_bytes[15:8] = b;
                    grp_phase = 2'd2;
                end
                else if (grp_phase == 2'd2)
                begin
                    word = {b, grp_bytes};
                    for (int k = 0; k < 8; k++)
                    begin
                        cand = word[3*k +: 3];
                        if (cand < 3'd6)
                        begin
                            vals[n] = {1'b0, cand == 3'd0};
                            n++;
                        end
                    end
                    grp_bytes = '0;
                    grp_phase = '0;
                end
                else
                begin
                    // phase 0, and the unreachable phase 3, start a new group
                    grp_bytes = {8'h00, b};
                    grp_phase = 2'd1;
                end
            end
            default:
            begin
                grp_bytes = '0;
                grp_phase = '0;
                for (int k = 0; k < 2; k++)
                begin
                    nib = b[4*k +: 4];
                    if (nib < 4'd12)
                    begin
                        vals[n] = {1'b0, nib == 4'd0};
                        n++;
                    end
                end
            end
        endcase
        if (eos)
        begin
            grp_bytes = '0;
            grp_phase = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            s.value = vals[i];
            s.last  = (i == n - 1);
            sample_q.push_back(s);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        noise_sample_t want;
        if (!rst_n)
        begin
            mode      = MODE_BIT_DIFF;
            grp_bytes = '0;
            grp_phase = '0;
            sample_q.delete();
            pending   = 0;
            errors    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                mode = mode_t'(cfg_wr_data);
            if (out_valid && !out_stall)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("unexpected sample: sample_value %0d, last_of_run %0b",
                           sample_value, last_of_run);
                    errors++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (sample_value !== want.value)
                    begin
                        $error("sample_value: expected %0d, got %0d",
                               $signed(want.value), sample_value);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_samples(data_byte, end_of_stream);
            pending = sample_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb
    import lns_pkg::*;
();

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned SEG_ITEMS     = 30;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              end_of_stream;
    logic              cfg_wr_en;
    logic [1:0]        cfg_wr_data;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [1:0] sample_value;
    logic              last_of_run;

    int unsigned pending_cnt;
    int unsigned mismatch_cnt;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned quiet_cycles = 0;

    lattice_noise_sampler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_value  (sample_value),
        .last_of_run   (last_of_run)
    );

    lns_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_value  (sample_value),
        .last_of_run   (last_of_run),
        .pending       (pending_cnt),
        .errors        (mismatch_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("lattice_noise_sampler test failed");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every predicted sample is out and the pipeline has settled
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_cnt != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic run_segment(input mode_t m, input int unsigned n_items);
        int unsigned sent;
        int unsigned glen;
        logic        e;
        set_mode(m);
        sent = 0;
        while (sent < n_items)
        begin
            if (m == MODE_THREE_REJECT)
            begin
                // mostly whole groups, some cut short by end of stream or left open
                if ($urandom_range(99) < 80)
                    glen = 3;
                else
                    glen = $urandom_range(1, 2);
                for (int i = 0; i < glen; i++)
                begin
                    if (i != glen - 1)
                        e = 1'b0;
                    else if (glen == 3)
                        e = ($urandom_range(99) < 25);
                    else
                        e = ($urandom_range(99) < 70);
                    send_req(rand_byte(), e);
                end
                sent += glen;
            end
            else
            begin
                send_req(rand_byte(), $urandom_range(99) < 10);
                sent++;
            end
            if ($urandom_range(99) < 4)
                drain_all();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        end_of_stream = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = MODE_BIT_DIFF;
        src_idle_pct  = 9;
        snk_idle_pct  = 77;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bit-pair difference straight out of reset
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h55, 1'b0);
        send_req(8'hAA, 1'b1);
        send_req(8'h1B, 1'b0);

        set_mode(MODE_ZERO_DIFF);
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b1);
        send_req(8'h3C, 1'b0);

        // all candidates zero, then all rejected
        set_mode(MODE_THREE_REJECT);
        send_req(8'h00, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'hFF, 1'b0);
        // partial group dropped by end of stream
        send_req(8'h12, 1'b0);
        send_req(8'h34, 1'b1);
        send_req(8'h56, 1'b0);
        send_req(8'h78, 1'b0);
        send_req(8'h9A, 1'b0);
        // open group survives a register write alone
        send_req(8'h11, 1'b0);
        set_mode(MODE_THREE_REJECT);
        send_req(8'h22, 1'b0);
        send_req(8'h33, 1'b0);
        // open group cleared by a byte in another mode
        send_req(8'hAB, 1'b0);
        set_mode(MODE_NIBBLE_REJECT);
        send_req(8'h00, 1'b0);
        set_mode(MODE_THREE_REJECT);
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h40, 1'b0);

        set_mode(MODE_NIBBLE_REJECT);
        send_req(8'hFF, 1'b0);
        send_req(8'hC0, 1'b0);
        send_req(8'hBB, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = (p == 0) ? 9 : (p == 1) ? 77 : 0;
            snk_idle_pct = (p == 0) ? 77 : (p == 1) ? 9 : 0;
            for (int s = 0; s < 4; s++)
                run_segment(mode_t'(2'((s + p) % 4)), SEG_ITEMS);
        end

        drain_all();
        if (mismatch_cnt == 0)
            $display("lattice_noise_sampler test passed");
        else
            $display("lattice_noise_sampler test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/lns_pkg.sv
rtl/core/lns_front.sv
rtl/core/lns_fifo.sv
rtl/core/lns_back.sv
rtl/core/lattice_noise_sampler.sv
sim/lns_checker.sv
sim/tb.sv
